// File: rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types, constants and helpers for the pixel format to RGBA converter.
// ----------------------------------------------------------------------------
package fpc_pkg;

  typedef enum logic [2:0] {
    FMT_RGB8  = 3'd0,
    FMT_BGR8  = 3'd1,
    FMT_RGBA8 = 3'd2,
    FMT_BGRA8 = 3'd3,
    FMT_Y8    = 3'd4,
    FMT_Y16   = 3'd5,
    FMT_YUYV  = 3'd6,
    FMT_UYVY  = 3'd7
  } fmt_t;

  localparam int unsigned FPC_QUEUE_DEPTH = 4;
  localparam logic [7:0]  ALPHA_OPAQUE    = 8'hFF;

  // Partial BT.601 terms, rounding offset already folded into the chroma terms
  localparam int unsigned TERM_W = 18;
  localparam int unsigned SUM_W  = 20;

  typedef struct packed {
    logic                     is_yuv;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [7:0]               alpha;
    logic signed [TERM_W-1:0] luma0;   // 298 * (Y0 - 16)
    logic signed [TERM_W-1:0] luma1;   // 298 * (Y1 - 16)
    logic signed [TERM_W-1:0] red_cr;  // 409*E + 128
    logic signed [TERM_W-1:0] grn_c;   // 128 - 100*D - 208*E
    logic signed [TERM_W-1:0] blu_cb;  // 516*D + 128
  } fpc_entry_t;

  // Floor shift by 8, then clamp to a byte
  function automatic logic [7:0] clamp_shift8(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-9:0] shifted;
    logic [7:0]              res;
    shifted = sum[SUM_W-1:8];
    if (shifted < 0) begin
      res = 8'd0;
    end else if (shifted > $signed((SUM_W-8)'(255))) begin
      res = 8'd255;
    end else begin
      res = shifted[7:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/fpc_front.sv
// ----------------------------------------------------------------------------
// fpc_front
// Holds the format register, takes items and classifies them into queue
// entries: channel routing for RGB/gray, precomputed products for YUV pairs.
// ----------------------------------------------------------------------------
module fpc_front
  import fpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       start,
  input  logic [7:0] byte0,
  input  logic [7:0] byte1,
  input  logic [7:0] byte2,
  input  logic [7:0] byte3,
  input  logic       full,
  output logic       busy,
  output logic       push,
  output fpc_entry_t entry
);

  fmt_t pixel_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGB8;
    end else if (cfg_wr_en) begin
      pixel_format <= fmt_t'(cfg_wr_data);
    end
  end

  assign busy = full;
  assign push = start && !full;

  logic [7:0]        y0, y1, u, v;
  logic signed [9:0] c0, c1;
  logic signed [7:0] d, e;

  always_comb begin
    y0 = byte0;
    u  = byte1;
    y1 = byte2;
    v  = byte3;
    if (pixel_format == FMT_UYVY) begin
      u  = byte0;
      y0 = byte1;
      v  = byte2;
      y1 = byte3;
    end
  end

  // Y - 16 and the chroma offsets (flipping the top bit subtracts 128)
  assign c0 = $signed({2'b00, y0}) - 10'sd16;
  assign c1 = $signed({2'b00, y1}) - 10'sd16;
  assign d  = $signed({~u[7], u[6:0]});
  assign e  = $signed({~v[7], v[6:0]});

  always_comb begin
    entry        = '0;
    entry.alpha  = ALPHA_OPAQUE;
    entry.luma0  = TERM_W'(c0) * 18'sd298;
    entry.luma1  = TERM_W'(c1) * 18'sd298;
    entry.red_cr = TERM_W'(e) * 18'sd409 + 18'sd128;
    entry.grn_c  = 18'sd128 - TERM_W'(d) * 18'sd100 - TERM_W'(e) * 18'sd208;
    entry.blu_cb = TERM_W'(d) * 18'sd516 + 18'sd128;
    unique case (pixel_format)
      FMT_RGB8: begin
        entry.red = byte0; entry.green = byte1; entry.blue = byte2;
      end
      FMT_BGR8: begin
        entry.red = byte2; entry.green = byte1; entry.blue = byte0;
      end
      FMT_RGBA8: begin
        entry.red = byte0; entry.green = byte1; entry.blue = byte2;
        entry.alpha = byte3;
      end
      FMT_BGRA8: begin
        entry.red = byte2; entry.green = byte1; entry.blue = byte0;
        entry.alpha = byte3;
      end
      FMT_Y8: begin
        entry.red = byte0; entry.green = byte0; entry.blue = byte0;
      end
      FMT_Y16: begin
        entry.red = byte1; entry.green = byte1; entry.blue = byte1;
      end
      FMT_YUYV, FMT_UYVY: begin
        entry.is_yuv = 1'b1;
      end
      default: begin
        entry.is_yuv = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/fpc_queue.sv
// ----------------------------------------------------------------------------
// fpc_queue
// Small FIFO of classified entries between the front and the back end.
// ----------------------------------------------------------------------------
module fpc_queue
  import fpc_pkg::*;
#(
  parameter int unsigned DEPTH = FPC_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  fpc_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output fpc_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fpc_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/fpc_back.sv
// ----------------------------------------------------------------------------
// fpc_back
// Drains the queue: one pixel per cycle while the queue holds an entry, two pixels for a YUV pair.
// Finishes the BT.601 sums, shifts, clamps and registers the result.
// ----------------------------------------------------------------------------
module fpc_back
  import fpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  fpc_entry_t head,
  output logic       pop,
  output logic       valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic       last_of_group
);

  logic                     phase;   // 1 on the second pixel of a YUV pair
  logic                     phase_next;
  logic signed [TERM_W-1:0] luma;
  logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [7:0]               red_next, green_next, blue_next, alpha_next;
  logic                     last_next;

  assign luma  = phase ? head.luma1 : head.luma0;
  assign sum_r = SUM_W'(luma) + SUM_W'(head.red_cr);
  assign sum_g = SUM_W'(luma) + SUM_W'(head.grn_c);
  assign sum_b = SUM_W'(luma) + SUM_W'(head.blu_cb);

  assign pop = !empty && (!head.is_yuv || phase);

  always_comb begin
    phase_next = phase;
    if (!empty && head.is_yuv) begin
      phase_next = !phase;
    end
  end

  always_comb begin
    if (head.is_yuv) begin
      red_next   = clamp_shift8(sum_r);
      green_next = clamp_shift8(sum_g);
      blue_next  = clamp_shift8(sum_b);
      alpha_next = ALPHA_OPAQUE;
      last_next  = phase;
    end else begin
      red_next   = head.red;
      green_next = head.green;
      blue_next  = head.blue;
      alpha_next = head.alpha;
      last_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      valid <= 1'b0;
    end else begin
      phase <= phase_next;
      valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    red           <= red_next;
    green         <= green_next;
    blue          <= blue_next;
    alpha         <= alpha_next;
    last_of_group <= last_next;
  end

endmodule

// File: rtl/pixel_format_to_rgba_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_to_rgba_converter
// Camera pixel formats to 8-bit RGBA, with BT.601 YUV 4:2:2 conversion.
// ----------------------------------------------------------------------------
// Usage:
//   Write the pixel format through cfg_wr_en / cfg_wr_data while idle
//   (0 RGB8, 1 BGR8, 2 RGBA8, 3 BGRA8, 4 Y8, 5 Y16, 6 YUYV, 7 UYVY).
//   An item (byte0..byte3) transfers on a clock edge with start high and
//   busy low. Results come out on red/green/blue/alpha with valid high for
//   one cycle each; last_of_group marks the final pixel of an item.
//   An item is written into the queue; the back end then computes its first
//   pixel and registers it onto the ports, and the second pixel of a YUV
//   pair follows in the next cycle.
//   Throughput: one item per cycle for RGB and gray formats while busy is
//   low; a YUYV/UYVY item yields two pixels, as the back end emits one pixel
//   per cycle. A queue of QUEUE_DEPTH entries absorbs bursts; busy is high
//   while it is full.
//   Reset clears the queue, the output strobe and sets the format to RGB8.
//   The receiver has no stall; every result is taken in its cycle.
// ----------------------------------------------------------------------------
module pixel_format_to_rgba_converter
  import fpc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = FPC_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] byte0,
  input  logic [7:0] byte1,
  input  logic [7:0] byte2,
  input  logic [7:0] byte3,
  output logic       valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic       last_of_group
);

  logic       push, pop, full, empty;
  fpc_entry_t push_entry, head;

  fpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start       (start),
    .byte0       (byte0),
    .byte1       (byte1),
    .byte2       (byte2),
    .byte3       (byte3),
    .full        (full),
    .busy        (busy),
    .push        (push),
    .entry       (push_entry)
  );

  fpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  fpc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .valid         (valid),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .last_of_group (last_of_group)
  );

endmodule

// File: rtl/fpc_checker.sv
// ----------------------------------------------------------------------------
// fpc_checker
// Port-level checks on the converter's result stream, bound to the top.
// ----------------------------------------------------------------------------
module fpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic [7:0] alpha,
  input logic       last_of_group
);

  // No result the cycle after reset is applied
  a_reset_quiet: assert property (@(posedge clk) rst |=> !valid)
    else $error("result strobe after reset");

  // First pixel of a pair is followed at once by the second
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    valid && !last_of_group |=> valid && last_of_group)
    else $error("second pixel of a pair missing");

  // Pair pixels are opaque
  a_pair_opaque: assert property (@(posedge clk) disable iff (rst)
    valid && !last_of_group |-> alpha == 8'hFF)
    else $error("YUV pixel alpha not opaque");

  a_pair_second_opaque: assert property (@(posedge clk) disable iff (rst)
    valid && !last_of_group |=> alpha == 8'hFF)
    else $error("second YUV pixel alpha not opaque");

endmodule

bind pixel_format_to_rgba_converter fpc_checker u_fpc_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (valid),
  .alpha         (alpha),
  .last_of_group (last_of_group)
);
